// File: hdl/hex_rect_tile_map_store_top_macros.svh
// assertion macros used by the tile map store back end
`ifndef HEX_RECT_TILE_MAP_STORE_TOP_MACROS_SVH
`define HEX_RECT_TILE_MAP_STORE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define HRT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile map store: implication check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define HRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile map store: next-cycle check failed");

`endif

// File: hdl/hrt_pkg.sv
// shared types and constants for the tile map store
`timescale 1ns / 1ps

package hrt_pkg;

  localparam int CMD_W      = 3;
  localparam int COORD_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CALC_W     = 15;

  localparam logic [CMD_W-1:0] CMD_SET_TILE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ_TILE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_AGENT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_AGENT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_map;
  } hrt_ctl_t;

  localparam int CTL_W = $bits(hrt_ctl_t);

endpackage

// File: hdl/hrt_front.sv
// front end: config registers, bounds check and store index per item
`timescale 1ns / 1ps

module hrt_front import hrt_pkg::*; #(
  parameter int MAX_SIDE = 64,
  parameter int ADDR_W   = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [COORD_W-1:0]    coord_q,
  input  logic [COORD_W-1:0]    coord_r,
  input  logic                  hold,
  output logic                  push_valid,
  input  logic                  push_ready,
  output hrt_ctl_t              push_ctl,
  output logic [ADDR_W-1:0]     push_addr
);

  localparam int MAX_RAD = (MAX_SIDE - 1) / 2;
  localparam logic [8:0] MAX_SIDE_W = 9'(MAX_SIDE);
  localparam logic [7:0] MAX_RAD_W  = 8'(MAX_RAD);

  logic       map_kind;
  logic [6:0] cols;
  logic [6:0] rows;
  logic [4:0] radius;

  logic [6:0] w;
  logic [6:0] h;
  logic [4:0] rad_c;
  logic [5:0] side;

  logic signed [9:0] qs, rs, ss, radw;
  logic signed [9:0] qa, ra, sa;
  logic signed [9:0] qq, rr;
  logic              rect_in, hex_in;

  logic [6:0]        mul_a, mul_b, mul_c;
  logic [13:0]       prod;
  logic [CALC_W-1:0] idx;

  function automatic logic signed [9:0] mag10(input logic signed [9:0] v);
    mag10 = v[9] ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      map_kind <= 1'b0;
      cols     <= 7'd64;
      rows     <= 7'd64;
      radius   <= 5'd31;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_KIND: map_kind <= cfg_data[0];
        CFG_COLS:     cols     <= cfg_data;
        CFG_ROWS:     rows     <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[4:0];
      endcase
    end
  end

  // dimensions clamped to what the store holds
  assign w     = ({2'b00, cols} > MAX_SIDE_W) ? 7'(MAX_SIDE) : cols;
  assign h     = ({2'b00, rows} > MAX_SIDE_W) ? 7'(MAX_SIDE) : rows;
  assign rad_c = ({3'b000, radius} > MAX_RAD_W) ? 5'(MAX_RAD) : radius;
  assign side  = {rad_c, 1'b1};

  assign rect_in = !coord_q[7] && !coord_r[7] && (coord_q[6:0] < w) && (coord_r[6:0] < h);

  assign qs   = 10'(signed'(coord_q));
  assign rs   = 10'(signed'(coord_r));
  assign ss   = qs + rs;
  assign radw = signed'({5'b00000, rad_c});
  assign qa   = mag10(qs);
  assign ra   = mag10(rs);
  assign sa   = mag10(ss);
  assign qq   = qs + radw;
  assign rr   = rs + radw;

  assign hex_in = (qa <= radw) && (ra <= radw) && (sa <= radw);

  // one multiplier shared by both geometries: a*b + c
  always_comb begin
    if (map_kind) begin
      mul_a = {1'b0, rr[5:0]};
      mul_b = {1'b0, side};
      mul_c = {1'b0, qq[5:0]};
    end else begin
      mul_a = coord_r[6:0];
      mul_b = w;
      mul_c = coord_q[6:0];
    end
  end

  assign prod = mul_a * mul_b;
  assign idx  = CALC_W'(prod) + CALC_W'(mul_c);

  assign s_tready        = push_ready && !hold;
  assign push_valid      = s_tvalid && s_tready;
  assign push_ctl.cmd    = cmd;
  assign push_ctl.in_map = map_kind ? hex_in : rect_in;
  assign push_addr       = ADDR_W'(idx);

endmodule

// File: hdl/hrt_queue.sv
// small fifo between the front end and the store back end
`timescale 1ns / 1ps

module hrt_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (PTR_W+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

// File: hdl/hrt_back.sv
// back end: tile and agent stores, clear sweep and result register
`timescale 1ns / 1ps
`include "hex_rect_tile_map_store_top_macros.svh"

module hrt_back import hrt_pkg::*; #(
  parameter int ADDR_W          = 12,
  parameter int TILE_STATE_BITS = 8,
  parameter int AGENT_BITS      = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  hrt_ctl_t                   q_ctl,
  input  logic [ADDR_W-1:0]          q_addr,
  input  logic [TILE_STATE_BITS-1:0] q_tile,
  input  logic [AGENT_BITS-1:0]      q_agent,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       res_inside,
  output logic [TILE_STATE_BITS-1:0] res_tile,
  output logic [AGENT_BITS-1:0]      res_agent,
  output logic                       init_busy
);

  localparam int DEPTH = 2 ** ADDR_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);
  localparam logic [AGENT_BITS-1:0] AGENT_EMPTY = '1;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic [TILE_STATE_BITS-1:0] tile_mem  [DEPTH];
  logic [AGENT_BITS-1:0]      agent_mem [DEPTH];

  logic                       state;
  logic                       init;
  logic [ADDR_W-1:0]          cnt;
  logic                       pop;
  hrt_ctl_t                   res_ctl;
  logic [TILE_STATE_BITS-1:0] tile_rd;
  logic [AGENT_BITS-1:0]      agent_rd;

  logic                       sweep;
  logic                       tile_we;
  logic                       agent_we;
  logic [ADDR_W-1:0]          wr_addr;
  logic [TILE_STATE_BITS-1:0] tile_wd;
  logic [AGENT_BITS-1:0]      agent_wd;

  // take the head item only when the result slot is free or draining
  assign pop     = (state == ST_RUN) && q_valid && (!res_valid || res_ready);
  assign q_ready = pop;
  assign sweep   = (state == ST_SWEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      init      <= 1'b1;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (pop && (q_ctl.cmd == CMD_CLEAR)) begin
            state <= ST_SWEEP;
            cnt   <= '0;
          end
          if (pop && (q_ctl.cmd != CMD_CLEAR)) res_valid <= 1'b1;
          else if (res_ready) res_valid <= 1'b0;
        end
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= ST_RUN;
            init  <= 1'b0;
            // the reset pass gives no item, a clear command gives one
            if (!init) res_valid <= 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_ctl <= q_ctl;
  end

  assign tile_we  = sweep || (pop && q_ctl.in_map && (q_ctl.cmd == CMD_SET_TILE));
  assign agent_we = sweep || (pop && q_ctl.in_map && (q_ctl.cmd == CMD_WRITE_AGENT));
  assign wr_addr  = sweep ? cnt : q_addr;
  assign tile_wd  = sweep ? '0 : q_tile;
  assign agent_wd = sweep ? AGENT_EMPTY : q_agent;

  always_ff @(posedge clk) begin
    if (tile_we) tile_mem[wr_addr] <= tile_wd;
    if (pop) tile_rd <= tile_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (agent_we) agent_mem[wr_addr] <= agent_wd;
    if (pop) agent_rd <= agent_mem[q_addr];
  end

  assign res_inside = res_ctl.in_map;
  assign res_tile   = (res_ctl.in_map && (res_ctl.cmd == CMD_READ_TILE)) ? tile_rd : '0;
  assign res_agent  = (res_ctl.in_map && (res_ctl.cmd == CMD_READ_AGENT)) ?
                      agent_rd : AGENT_EMPTY;
  assign init_busy  = init;

  `HRT_ASSERT_IMPLY(a_no_pop_in_sweep, state == ST_SWEEP, !pop)
  `HRT_ASSERT_IMPLY(a_no_result_in_sweep, state == ST_SWEEP, !res_valid)
  `HRT_ASSERT_IMPLY(a_init_only_in_sweep, init, state == ST_SWEEP)
  `HRT_ASSERT_NEXT(a_sweep_runs_on, (state == ST_SWEEP) && (cnt != LAST), state == ST_SWEEP)

endmodule

// File: hdl/hex_rect_tile_map_store_top.sv
// top level of the rectangular / hexagonal tile map store
//
// Commands come in on the s_ stream: s_tuser carries the command, s_tdata the
// coordinate pair and the values to write. Every command gives exactly one
// item on the m_ stream: the in-bounds flag, the tile state read back and the
// agent ID read back.
// Geometry comes from four registers on the cfg_ write port; write them only
// while no command is in flight.
// The front end works out the bounds and the store index in the accept
// cycle, a two-entry fifo follows, and the back end does one store access
// per cycle, so the block sustains one item per cycle for set, read and
// write commands while m_tready stays high and no clear sweep runs.
// A clear command holds the back end while it sweeps every entry of both
// stores, MAX_SIDE*MAX_SIDE rounded up to a power of two (4096 by default);
// its result item follows the sweep, and the front end keeps filling the fifo.
// After reset the same sweep runs once, s_tready stays low for those cycles,
// and config writes are taken throughout.
// When m_tready is low the result holds in its register, the fifo absorbs up
// to two more items, and then s_tready drops.
`timescale 1ns / 1ps

module hex_rect_tile_map_store_top import hrt_pkg::*; #(
  parameter int MAX_SIDE        = 64,
  parameter int TILE_STATE_BITS = 8,
  parameter int AGENT_BITS      = 32,
  localparam int IN_BITS  = 2 * COORD_W + TILE_STATE_BITS + AGENT_BITS,
  localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 1 + TILE_STATE_BITS + AGENT_BITS,
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DW-1:0]      s_tdata,   // coord_q, coord_r, new_tile_state, new_agent
  input  logic [CMD_W-1:0]      s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DW-1:0]     m_tdata    // inside_res, tile_state_out, agent_out
);

  localparam int ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int TILE_LO = 2 * COORD_W;
  localparam int AG_LO   = TILE_LO + TILE_STATE_BITS;
  localparam int Q_W     = CTL_W + ADDR_W + TILE_STATE_BITS + AGENT_BITS;

  logic                       hold;
  logic                       push_valid;
  logic                       push_ready;
  hrt_ctl_t                   push_ctl;
  logic [ADDR_W-1:0]          push_addr;
  logic [Q_W-1:0]             push_data;

  logic                       pop_valid;
  logic                       pop_ready;
  logic [Q_W-1:0]             pop_data;
  hrt_ctl_t                   pop_ctl;
  logic [ADDR_W-1:0]          pop_addr;
  logic [TILE_STATE_BITS-1:0] pop_tile;
  logic [AGENT_BITS-1:0]      pop_agent;

  logic                       res_inside;
  logic [TILE_STATE_BITS-1:0] res_tile;
  logic [AGENT_BITS-1:0]      res_agent;

  hrt_front #(
    .MAX_SIDE (MAX_SIDE),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .cmd        (s_tuser),
    .coord_q    (s_tdata[COORD_W-1:0]),
    .coord_r    (s_tdata[2*COORD_W-1:COORD_W]),
    .hold       (hold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_addr  (push_addr)
  );

  assign push_data = {s_tdata[AG_LO+AGENT_BITS-1:AG_LO],
                      s_tdata[TILE_LO+TILE_STATE_BITS-1:TILE_LO],
                      push_addr, push_ctl};

  hrt_queue #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  assign {pop_agent, pop_tile, pop_addr, pop_ctl} = pop_data;

  hrt_back #(
    .ADDR_W          (ADDR_W),
    .TILE_STATE_BITS (TILE_STATE_BITS),
    .AGENT_BITS      (AGENT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_ctl      (pop_ctl),
    .q_addr     (pop_addr),
    .q_tile     (pop_tile),
    .q_agent    (pop_agent),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_inside (res_inside),
    .res_tile   (res_tile),
    .res_agent  (res_agent),
    .init_busy  (hold)
  );

  assign m_tdata = OUT_DW'({res_agent, res_tile, res_inside});

endmodule

// File: tb/hex_rect_tile_map_store_top_tb.sv
// self-checking testbench for the rectangular / hexagonal tile map store
`timescale 1ns / 1ps

module hex_rect_tile_map_store_top_tb;
  import hrt_pkg::*;

  localparam int TILE_W  = 8;
  localparam int AGENT_W = 32;
  localparam int SIDE    = 64;
  localparam int DEPTH   = SIDE * SIDE;
  localparam int MAX_RAD = (SIDE - 1) / 2;
  localparam int IN_DW   = 56;
  localparam int OUT_DW  = 48;
  localparam int HOLD_CYCLES = 400;

  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam logic [AGENT_W-1:0] AGENT_EMPTY = '1;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] q;
    logic signed [COORD_W-1:0] r;
    logic [TILE_W-1:0]         tile;
    logic [AGENT_W-1:0]        agent;
  } map_cmd_t;

  typedef struct {
    logic               in_map;
    logic [TILE_W-1:0]  tile;
    logic [AGENT_W-1:0] agent;
  } map_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DW-1:0]      s_tdata = '0;  // coord_q, coord_r, new_tile_state, new_agent
  logic [CMD_W-1:0]      s_tuser = '0;  // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DW-1:0]     m_tdata;       // inside_res, tile_state_out, agent_out

  hex_rect_tile_map_store_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // geometry as the block should see it
  logic       geo_hex = 1'b0;
  logic [6:0] geo_cols = 7'd64;
  logic [6:0] geo_rows = 7'd64;
  logic [4:0] geo_radius = 5'd31;

  logic [TILE_W-1:0]  tile_mem [DEPTH];
  logic [AGENT_W-1:0] agent_mem [DEPTH];

  map_cmd_t   cmd_backlog [$];
  map_reply_t replies_due [$];
  map_cmd_t   offered;
  logic       item_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       rx_hold = 1'b0;
  logic       pressure_go = 1'b0;
  int         mismatches = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void wipe_map();
    for (int i = 0; i < DEPTH; i++) begin
      tile_mem[i] = '0;
      agent_mem[i] = AGENT_EMPTY;
    end
  endfunction

  // bounds check, store access and reply for one command
  function automatic map_reply_t apply_map_cmd(map_cmd_t c);
    int qi, ri, w, h, rad, idx, s;
    logic hit;
    map_reply_t rep;
    qi = c.q;
    ri = c.r;
    if (!geo_hex) begin
      w = (geo_cols > SIDE) ? SIDE : geo_cols;
      h = (geo_rows > SIDE) ? SIDE : geo_rows;
      hit = (qi >= 0) && (qi < w) && (ri >= 0) && (ri < h);
      idx = ri * w + qi;
    end else begin
      rad = (geo_radius > MAX_RAD) ? MAX_RAD : geo_radius;
      s = qi + ri;
      hit = ((qi < 0) ? -qi : qi) <= rad && ((ri < 0) ? -ri : ri) <= rad &&
            ((s < 0) ? -s : s) <= rad;
      idx = (ri + rad) * (2 * rad + 1) + (qi + rad);
    end
    if (hit) idx = idx % DEPTH;
    rep.in_map = hit;
    rep.tile = '0;
    rep.agent = AGENT_EMPTY;
    case (c.cmd)
      CMD_SET_TILE: begin
        if (hit) tile_mem[idx] = c.tile;
      end
      CMD_READ_TILE: begin
        if (hit) rep.tile = tile_mem[idx];
      end
      CMD_READ_AGENT: begin
        if (hit) rep.agent = agent_mem[idx];
      end
      CMD_WRITE_AGENT: begin
        if (hit) agent_mem[idx] = c.agent;
      end
      CMD_CLEAR: begin
        wipe_map();
      end
      default: ;
    endcase
    return rep;
  endfunction

  // mostly coordinates near or inside the current map, some anywhere
  function automatic map_cmd_t random_map_cmd();
    map_cmd_t c;
    int pick, w, h, lim, qi, ri, lo, hi;
    pick = $urandom_range(999);
    if (pick < 12) c.cmd = CMD_CLEAR;
    else if (pick < 40) c.cmd = CMD_W'($urandom_range(CMD_UNUSED_7, CMD_UNUSED_5));
    else c.cmd = CMD_W'($urandom_range(CMD_WRITE_AGENT, CMD_SET_TILE));
    c.tile = TILE_W'($urandom);
    pick = $urandom_range(19);
    c.agent = (pick == 0) ? AGENT_EMPTY : (pick == 1) ? '0 : $urandom;
    c.q = COORD_W'($urandom);
    c.r = COORD_W'($urandom);
    if ($urandom_range(9) < 8) begin
      if (!geo_hex) begin
        w = (geo_cols > SIDE) ? SIDE : geo_cols;
        h = (geo_rows > SIDE) ? SIDE : geo_rows;
        // a small corner window half the time so reads find earlier writes
        lim = ($urandom_range(1) != 0) ? w : ((w < 6) ? w : 6);
        c.q = COORD_W'($urandom_range(lim));
        lim = ($urandom_range(1) != 0) ? h : ((h < 6) ? h : 6);
        c.r = COORD_W'($urandom_range(lim));
      end else begin
        lim = ($urandom_range(1) != 0) ? geo_radius : ((geo_radius < 3) ? geo_radius : 3);
        qi = $urandom_range(2 * lim);
        qi = qi - lim;
        lo = (-lim > -qi - lim) ? -lim : -qi - lim;
        hi = (lim < lim - qi) ? lim : lim - qi;
        ri = $urandom_range(hi - lo);
        ri = ri + lo;
        // step just past the rim now and then
        if ($urandom_range(9) == 0) qi = qi + 1;
        c.q = COORD_W'(qi);
        c.r = COORD_W'(ri);
      end
    end
    return c;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = cmd_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {offered.agent, offered.tile, offered.r, offered.q};
        s_tuser <= offered.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the fifo fills and the input stalls
  initial begin
    wait (pressure_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // predict on accept, check on result
  always @(posedge clk) begin
    map_reply_t want;
    item_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) replies_due.push_back(apply_map_cmd(offered));
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        $error("result item with no command outstanding");
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[0] !== want.in_map) begin
          $error("inside_res: expected %0d, got %0d", want.in_map, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[TILE_W:1] !== want.tile) begin
          $error("tile_state_out: expected %0h, got %0h", want.tile, m_tdata[TILE_W:1]);
          mismatches++;
        end
        if (m_tdata[TILE_W+AGENT_W:TILE_W+1] !== want.agent) begin
          $error("agent_out: expected %0h, got %0h", want.agent,
                 m_tdata[TILE_W+AGENT_W:TILE_W+1]);
          mismatches++;
        end
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] op, input int q, input int r,
                          input int tile, input logic [AGENT_W-1:0] agent);
    map_cmd_t c;
    c.cmd = op;
    c.q = COORD_W'(q);
    c.r = COORD_W'(r);
    c.tile = TILE_W'(tile);
    c.agent = agent;
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || s_tvalid || replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_MAP_KIND: geo_hex = v[0];
      CFG_COLS:     geo_cols = v;
      CFG_ROWS:     geo_rows = v;
      CFG_RADIUS:   geo_radius = v[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mode 0 no idling, 1 sender idle, 2 receiver stalls, 3 light idling on both
  task automatic run_phase(input int kind, input int cols, input int rows, input int rad,
                           input int n, input int mode, input logic squeeze);
    wait_drained();
    write_reg(CFG_MAP_KIND, kind);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_RADIUS, rad);
    send_idle_pct = (mode == 1) ? 82 : (mode == 3) ? 16 : 0;
    recv_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 16 : 0;
    repeat (n) cmd_backlog.push_back(random_map_cmd());
    if (squeeze) pressure_go = 1'b1;
  endtask

  initial begin
    wipe_map();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, on the reset geometry of a 64 x 64 rectangle
    push_cmd(CMD_READ_TILE, 0, 0, 0, '0);
    push_cmd(CMD_READ_AGENT, 0, 0, 0, '0);
    push_cmd(CMD_SET_TILE, 0, 0, 255, '0);
    push_cmd(CMD_READ_TILE, 0, 0, 0, '0);
    push_cmd(CMD_SET_TILE, 63, 63, 8'ha5, '0);
    push_cmd(CMD_READ_TILE, 63, 63, 0, '0);
    push_cmd(CMD_WRITE_AGENT, 0, 63, 0, '0);
    push_cmd(CMD_READ_AGENT, 0, 63, 0, '0);
    push_cmd(CMD_WRITE_AGENT, 63, 0, 0, 32'h8000_0001);
    push_cmd(CMD_READ_AGENT, 63, 0, 0, '0);
    // out of bounds on every side
    push_cmd(CMD_SET_TILE, 64, 0, 8'h5a, '0);
    push_cmd(CMD_READ_TILE, 64, 0, 0, '0);
    push_cmd(CMD_READ_TILE, -1, 0, 0, '0);
    push_cmd(CMD_READ_AGENT, 0, 64, 0, '0);
    push_cmd(CMD_WRITE_AGENT, -128, -128, 0, 32'h1234_5678);
    push_cmd(CMD_READ_AGENT, 127, 127, 0, '0);
    push_cmd(CMD_READ_TILE, -128, 127, 0, '0);
    push_cmd(CMD_UNUSED_5, 0, 0, 8'h11, 32'h0);
    push_cmd(CMD_UNUSED_6, 63, 0, 8'h22, 32'h0);
    push_cmd(CMD_UNUSED_7, 0, 63, 8'h33, 32'h0);
    push_cmd(CMD_CLEAR, 0, 0, 0, '0);
    push_cmd(CMD_READ_TILE, 0, 0, 0, '0);
    push_cmd(CMD_READ_AGENT, 63, 0, 0, '0);
    push_cmd(CMD_READ_TILE, 63, 63, 0, '0);

    run_phase(0, 8, 5, 0, 150, 1, 1'b0);
    run_phase(1, 8, 5, 3, 150, 2, 1'b0);
    run_phase(1, 0, 0, 31, 130, 3, 1'b0);
    run_phase(1, 64, 64, 0, 80, 0, 1'b0);
    run_phase(0, 1, 64, 0, 130, 1, 1'b0);
    // dimensions above the store side clamp to it
    run_phase(0, 127, 100, 5, 130, 2, 1'b0);
    // empty maps
    run_phase(0, 0, 10, 5, 80, 3, 1'b0);
    run_phase(0, 10, 0, 5, 60, 0, 1'b0);
    run_phase(0, 64, 1, 2, 130, 1, 1'b0);
    run_phase(1, 3, 3, 17, 130, 2, 1'b0);
    run_phase(0, 13, 7, 31, 150, 3, 1'b0);
    run_phase(0, 4, 4, 1, 100, 0, 1'b1);
    run_phase(0, 64, 64, 31, 110, 0, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
